@@ hw/rtl/dpap_pkg.sv @@
// Shared types, register codes and helpers for the debug port / MEM-AP block.
`default_nettype none

package dpap_pkg;

  localparam int unsigned MEM_WORDS_DEF = 4096;
  localparam int unsigned LANES         = 4;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_DPIDR   = 2'd0,
    CFG_AP_CFG  = 2'd1,
    CFG_AP_BASE = 2'd2,
    CFG_AP_IDR  = 2'd3
  } cfg_reg_e;

  // DP registers, selected by offset bits 3:2.
  typedef enum logic [1:0] {
    DP_IDR    = 2'd0,
    DP_CTRL   = 2'd1,
    DP_SELECT = 2'd2,
    DP_RDBUFF = 2'd3
  } dp_reg_e;

  // AP registers, selected by offset bits 7:2.
  localparam logic [5:0] AP_CSW  = 6'h00;
  localparam logic [5:0] AP_TAR  = 6'h01;
  localparam logic [5:0] AP_DRW  = 6'h03;
  localparam logic [5:0] AP_CFG  = 6'h3D;
  localparam logic [5:0] AP_BASE = 6'h3E;
  localparam logic [5:0] AP_IDR  = 6'h3F;

  // CSW fields.
  localparam logic [2:0] CSW_SIZE_BYTE  = 3'd0;
  localparam logic [2:0] CSW_SIZE_HALF  = 3'd1;
  localparam logic [1:0] CSW_INC_SINGLE = 2'd1;
  localparam int unsigned CSW_DBGSWEN_BIT = 31;

  // CTRL/STAT power-up request and acknowledge bits.
  localparam int unsigned CSYSPWRUPREQ_BIT = 30;
  localparam int unsigned CSYSPWRUPACK_BIT = 31;
  localparam int unsigned CDBGPWRUPREQ_BIT = 28;
  localparam int unsigned CDBGPWRUPACK_BIT = 29;

  typedef struct packed {
    logic        rd;
    logic        ap;
    logic [7:0]  offset;
    logic [31:0] wdata;
  } req_t;

  // Memory request: read strobe and per-lane write enables.
  typedef struct packed {
    logic             rd;
    logic [LANES-1:0] be;
  } mem_req_t;

  // Word index tracker command.
  typedef struct packed {
    logic        load;
    logic        step;
    logic        wrap;
    logic [31:0] value;
  } idx_cmd_t;

  function automatic logic [31:0] lane_mask(input logic [LANES-1:0] be);
    logic [31:0] m;
    m = '0;
    for (int l = 0; l < LANES; l++) begin
      m[8*l +: 8] = {8{be[l]}};
    end
    return m;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/dpap_cfg_if.sv @@
// Configuration write channel.
`default_nettype none

interface dpap_cfg_if;
  logic               valid;
  logic               ready;
  dpap_pkg::cfg_reg_e index;
  logic [31:0]        data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/dpap_req_if.sv @@
// Register access request channel.
`default_nettype none

interface dpap_req_if;
  logic        valid;
  logic        ready;
  logic        access_is_read;
  logic        to_access_port;
  logic [7:0]  reg_offset;
  logic [31:0] write_data;

  modport source (output valid, output access_is_read, output to_access_port,
                  output reg_offset, output write_data, input ready);
  modport sink   (input valid, input access_is_read, input to_access_port,
                  input reg_offset, input write_data, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/dpap_rsp_if.sv @@
// Read data response channel.
`default_nettype none

interface dpap_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_data;

  modport source (output valid, output read_data, input ready);
  modport sink   (input valid, input read_data, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/adiv5_dp_mem_ap_model.sv @@
// Top level: ADIv5 DP plus one MEM-AP at register-access level.
//
//  channel  dir  handshake     payload
//  cfg_i    in   valid/ready   index (register), data
//  req_i    in   valid/ready   access_is_read, to_access_port, reg_offset, write_data
//  rsp_o    out  valid/ready   read_data (one item per request)
//
// One item per cycle unless stalled: request register -> decode/state update ->
// response register. A TAR write holds the next item while the word index unit
// reduces it modulo MEM_WORDS; no hold when MEM_WORDS is a power of two. After
// reset the RAM clearing sweep zeroes every word, no requests taken. A stalled
// response keeps its item; the request register still takes one more.
`default_nettype none

module adiv5_dp_mem_ap_model #(
  parameter int unsigned MEM_WORDS = dpap_pkg::MEM_WORDS_DEF
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  dpap_cfg_if.sink    cfg_i,
  dpap_req_if.sink    req_i,
  dpap_rsp_if.source  rsp_o
);

  localparam int unsigned AW = $clog2(MEM_WORDS);

  // ---------------------------------------------------------------------
  // Configuration registers (always ready)
  // ---------------------------------------------------------------------
  logic [31:0] dpidr_q, ap_cfg_q, ap_base_q, ap_idr_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dpidr_q   <= '0;
      ap_cfg_q  <= '0;
      ap_base_q <= '0;
      ap_idr_q  <= '0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        dpap_pkg::CFG_DPIDR:   dpidr_q   <= cfg_i.data;
        dpap_pkg::CFG_AP_CFG:  ap_cfg_q  <= cfg_i.data;
        dpap_pkg::CFG_AP_BASE: ap_base_q <= cfg_i.data;
        dpap_pkg::CFG_AP_IDR:  ap_idr_q  <= cfg_i.data;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Request register and response register
  // ---------------------------------------------------------------------
  dpap_pkg::req_t a_q;
  logic           a_valid_q;
  logic [31:0]    b_data_q;
  logic           b_valid_q;
  logic           adv;
  logic           accept_in;
  logic           idx_busy;
  logic           mem_clearing;
  logic [31:0]    res;

  assign adv       = a_valid_q & (~b_valid_q | rsp_o.ready) & ~idx_busy;
  assign req_i.ready = ~mem_clearing & (~a_valid_q | adv);
  assign accept_in = req_i.valid & req_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (accept_in) begin
      a_valid_q <= 1'b1;
    end else if (adv) begin
      a_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_in) begin
      a_q <= '{rd:     req_i.access_is_read,
               ap:     req_i.to_access_port,
               offset: req_i.reg_offset,
               wdata:  req_i.write_data};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (adv) begin
      b_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      b_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      b_data_q <= res;
    end
  end

  assign rsp_o.valid     = b_valid_q;
  assign rsp_o.read_data = b_data_q;

  // ---------------------------------------------------------------------
  // Architectural state
  // ---------------------------------------------------------------------
  logic [31:0] posted_q, csw_q, tar_q, ctrl_q;
  logic [7:0]  apsel_q;
  // A DRW read posts the RAM word, which the RAM read register captures as the
  // posted state updates; post_mem_q/post_be_q say to take it from there.
  logic                          post_mem_q;
  logic [dpap_pkg::LANES-1:0]    post_be_q;

  logic [31:0]   mem_rdata;
  logic [AW-1:0] idx;
  logic [31:0]   posted_eff;

  assign posted_eff = post_mem_q ? (mem_rdata & dpap_pkg::lane_mask(post_be_q)) : posted_q;

  // Size decode on the TAR byte lane
  logic [2:0]                 tar_step;
  logic [dpap_pkg::LANES-1:0] be;
  logic [31:0]                tar_inc;
  logic                       auto_inc;

  always_comb begin
    unique case (csw_q[2:0])
      dpap_pkg::CSW_SIZE_BYTE: begin
        tar_step = 3'd1;
        be       = 4'b0001 << tar_q[1:0];
      end
      dpap_pkg::CSW_SIZE_HALF: begin
        tar_step = 3'd2;
        be       = tar_q[1] ? 4'b1100 : 4'b0011;
      end
      default: begin
        tar_step = 3'd4;
        be       = 4'b1111;
      end
    endcase
  end

  assign tar_inc  = tar_q + 32'(tar_step);
  assign auto_inc = (csw_q[5:4] == dpap_pkg::CSW_INC_SINGLE);

  // Access decode
  logic [5:0]          ap_reg;
  dpap_pkg::dp_reg_e   dp_reg;
  logic                post_load;
  logic                post_from_mem;
  logic [31:0]         post_val;
  logic [31:0]         csw_d, tar_d, ctrl_d;
  logic [7:0]          apsel_d;
  logic                do_inc;
  dpap_pkg::mem_req_t  mem_req;
  dpap_pkg::mem_req_t  mem_req_g;
  dpap_pkg::idx_cmd_t  idx_cmd;
  dpap_pkg::idx_cmd_t  idx_cmd_g;

  assign ap_reg = a_q.offset[7:2];
  assign dp_reg = dpap_pkg::dp_reg_e'(a_q.offset[3:2]);

  always_comb begin
    res           = '0;
    post_load     = 1'b0;
    post_from_mem = 1'b0;
    post_val      = '0;
    csw_d         = csw_q;
    tar_d         = tar_q;
    ctrl_d        = ctrl_q;
    apsel_d       = apsel_q;
    do_inc        = 1'b0;
    mem_req       = '0;
    idx_cmd       = '0;
    idx_cmd.value = a_q.wdata;

    if (a_q.ap) begin
      if (a_q.rd) begin
        // posted read: return the previous value, post a new one
        res       = posted_eff;
        post_load = 1'b1;
        if (apsel_q != '0) begin
          post_val = (ap_reg == dpap_pkg::AP_BASE) ? '1 : '0;
        end else begin
          unique case (ap_reg)
            dpap_pkg::AP_CSW: begin
              post_val = csw_q;
              post_val[dpap_pkg::CSW_DBGSWEN_BIT] = 1'b1;
            end
            dpap_pkg::AP_TAR:  post_val = tar_q;
            dpap_pkg::AP_DRW: begin
              mem_req.rd    = 1'b1;
              post_from_mem = 1'b1;
              do_inc        = auto_inc;
            end
            dpap_pkg::AP_CFG:  post_val = ap_cfg_q;
            dpap_pkg::AP_BASE: post_val = ap_base_q;
            dpap_pkg::AP_IDR:  post_val = ap_idr_q;
            default:           post_val = '0;
          endcase
        end
      end else begin
        // writes reach CSW, TAR and DRW whatever APSEL says
        unique case (ap_reg)
          dpap_pkg::AP_CSW: csw_d = a_q.wdata;
          dpap_pkg::AP_TAR: begin
            tar_d        = a_q.wdata;
            idx_cmd.load = 1'b1;
          end
          dpap_pkg::AP_DRW: begin
            mem_req.be = be;
            do_inc     = auto_inc;
          end
          default: ;
        endcase
      end
    end else begin
      if (a_q.rd) begin
        unique case (dp_reg)
          dpap_pkg::DP_IDR: res = dpidr_q;
          dpap_pkg::DP_CTRL: begin
            res = ctrl_q;
            if (ctrl_q[dpap_pkg::CSYSPWRUPREQ_BIT]) res[dpap_pkg::CSYSPWRUPACK_BIT] = 1'b1;
            if (ctrl_q[dpap_pkg::CDBGPWRUPREQ_BIT]) res[dpap_pkg::CDBGPWRUPACK_BIT] = 1'b1;
          end
          dpap_pkg::DP_SELECT: res = '0;
          dpap_pkg::DP_RDBUFF: res = posted_eff;
        endcase
      end else begin
        unique case (dp_reg)
          dpap_pkg::DP_CTRL:   ctrl_d  = a_q.wdata;
          dpap_pkg::DP_SELECT: apsel_d = a_q.wdata[31:24];
          default: ;
        endcase
      end
    end

    if (do_inc) begin
      tar_d        = tar_inc;
      idx_cmd.step = (tar_inc[31:2] != tar_q[31:2]);
      idx_cmd.wrap = (tar_inc[31:2] == '0);
    end
  end

  assign mem_req_g = adv ? mem_req : '0;
  assign idx_cmd_g = adv ? idx_cmd : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      posted_q   <= '0;
      post_mem_q <= 1'b0;
      post_be_q  <= '0;
      csw_q      <= '0;
      tar_q      <= '0;
      ctrl_q     <= '0;
      apsel_q    <= '0;
    end else if (adv) begin
      if (post_load) begin
        posted_q   <= post_val;
        post_mem_q <= post_from_mem;
        post_be_q  <= be;
      end
      csw_q   <= csw_d;
      tar_q   <= tar_d;
      ctrl_q  <= ctrl_d;
      apsel_q <= apsel_d;
    end
  end

  // ---------------------------------------------------------------------
  // Word index unit and target RAM
  // ---------------------------------------------------------------------
  dpap_widx #(
    .MEM_WORDS (MEM_WORDS)
  ) u_widx (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (idx_cmd_g),
    .idx_o  (idx),
    .busy_o (idx_busy)
  );

  dpap_mem #(
    .MEM_WORDS (MEM_WORDS)
  ) u_mem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (mem_req_g),
    .addr_i     (idx),
    .wdata_i    (a_q.wdata),
    .rdata_o    (mem_rdata),
    .clearing_o (mem_clearing)
  );

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_no_req_while_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_clearing |-> !req_i.ready)
    else $error("request taken during RAM clear");

  a_idx_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !idx_busy |-> (32'(idx) < MEM_WORDS))
    else $error("word index out of range");

  a_post_mem_from_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(post_mem_q) |-> $past(mem_req_g.rd))
    else $error("posted RAM value without RAM read");

  a_write_returns_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && !a_q.rd) |=> (b_valid_q && b_data_q == '0))
    else $error("write access returned nonzero data");

endmodule

`default_nettype wire

@@ hw/rtl/dpap_mem.sv @@
// Byte-lane target RAM with a clearing sweep after reset.
`default_nettype none

module dpap_mem #(
  parameter int unsigned MEM_WORDS = dpap_pkg::MEM_WORDS_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire dpap_pkg::mem_req_t   req_i,
  input  wire logic [$clog2(MEM_WORDS)-1:0] addr_i,
  input  wire logic [31:0]          wdata_i,
  output logic [31:0]               rdata_o,
  output logic                      clearing_o
);

  localparam int unsigned AW = $clog2(MEM_WORDS);

  logic [dpap_pkg::LANES-1:0][7:0] mem_array [MEM_WORDS];
  logic [31:0]   rdata_q;
  logic          clr_q;
  logic [AW-1:0] clr_idx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= 1'b1;
      clr_idx_q <= '0;
    end else if (clr_q) begin
      if (clr_idx_q == AW'(MEM_WORDS - 1)) begin
        clr_q <= 1'b0;
      end
      clr_idx_q <= clr_idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_q) begin
      mem_array[clr_idx_q] <= '0;
    end else begin
      for (int l = 0; l < dpap_pkg::LANES; l++) begin
        if (req_i.be[l]) begin
          mem_array[addr_i][l] <= wdata_i[8*l +: 8];
        end
      end
    end
    if (req_i.rd) begin
      rdata_q <= mem_array[addr_i];
    end
  end

  assign rdata_o    = rdata_q;
  assign clearing_o = clr_q;

endmodule

`default_nettype wire

@@ hw/rtl/dpap_widx.sv @@
// Memory word index tracker: (TAR >> 2) mod MEM_WORDS, kept incrementally.
`default_nettype none

module dpap_widx #(
  parameter int unsigned MEM_WORDS = dpap_pkg::MEM_WORDS_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire dpap_pkg::idx_cmd_t   cmd_i,
  output logic [$clog2(MEM_WORDS)-1:0] idx_o,
  output logic                      busy_o
);

  localparam int unsigned   AW      = $clog2(MEM_WORDS);
  localparam bit            IS_POW2 = ((1 << AW) == MEM_WORDS);
  // floor(2^30 / MEM_WORDS): the quotient estimate is exact or one low
  localparam logic [26:0]   RECIP   = 27'((64'd1 << 30) / 64'(MEM_WORDS));
  localparam logic [29:0]   MODULUS = 30'(MEM_WORDS);
  localparam logic [AW-1:0] LAST    = AW'(MEM_WORDS - 1);

  logic [AW-1:0] idx_q;
  logic [29:0]   num_q;
  logic [26:0]   quo_q;
  logic [1:0]    phase_q;
  logic [56:0]   prod;
  logic [29:0]   quo_mul;
  logic [29:0]   rem_est;
  logic [29:0]   rem;

  // stage 1: quotient estimate by reciprocal; stage 2: remainder, one fix-up
  assign prod    = {27'd0, num_q} * {30'd0, RECIP};
  assign quo_mul = {3'd0, quo_q} * MODULUS;
  assign rem_est = num_q - quo_mul;
  assign rem     = (rem_est >= MODULUS) ? rem_est - MODULUS : rem_est;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      num_q   <= '0;
      quo_q   <= '0;
      phase_q <= '0;
    end else if (cmd_i.load) begin
      if (IS_POW2) begin
        idx_q <= cmd_i.value[AW+1:2];
      end else begin
        num_q   <= cmd_i.value[31:2];
        phase_q <= 2'd2;
      end
    end else if (phase_q == 2'd2) begin
      quo_q   <= prod[56:30];
      phase_q <= 2'd1;
    end else if (phase_q == 2'd1) begin
      idx_q   <= rem[AW-1:0];
      phase_q <= 2'd0;
    end else if (cmd_i.step) begin
      // TAR moved into the next word; wrap at MEM_WORDS or at 2^30 words
      idx_q <= (cmd_i.wrap || idx_q == LAST) ? '0 : idx_q + 1'b1;
    end
  end

  assign idx_o  = idx_q;
  assign busy_o = (phase_q != 2'd0);

endmodule

`default_nettype wire
